### hw/rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants for the lru key-value cache
// widths of the payload fields, request kind codes and the cell control group
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // request kinds
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // returned by a get that misses
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // control group broadcast from the top level to every cell
    typedef struct packed {
        logic lookup;   // register the key compare
        logic move;     // close the gap at the hit (or front) and load the top cell
        logic append;   // load the first empty cell
    } lrukv_ctl_t;

endpackage

### hw/rtl/lrukv_cell.sv
// ----------------------------------------------------------------------------
// lrukv_cell: one entry of the recency-ordered row
// holds valid, key and value; compares against the request key and shifts
// towards the least recent end when a gap opens below it
// ----------------------------------------------------------------------------
module lrukv_cell
    import lrukv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lrukv_ctl_t        ctl,
    input  logic [DATA_W-1:0] cmp_key,
    input  logic [DATA_W-1:0] new_key,
    input  logic [DATA_W-1:0] new_value,
    input  logic              ge_in,
    output logic              ge_out,
    input  logic              valid_lo,
    input  logic              valid_hi,
    input  logic [DATA_W-1:0] key_hi,
    input  logic [DATA_W-1:0] value_hi,
    output logic              valid,
    output logic [DATA_W-1:0] key,
    output logic [DATA_W-1:0] value,
    output logic              match
);

    logic              valid_reg;
    logic              valid_next;
    logic              match_reg;
    logic              match_next;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] key_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              ge_self;
    logic              shift;
    logic              load_top;
    logic              load_app;

    // at or above the removed position
    assign ge_self  = ge_in | match_reg;
    assign ge_out   = ge_self;
    assign shift    = ctl.move & ge_self & valid_hi;
    assign load_top = ctl.move & valid_reg & ~valid_hi;
    assign load_app = ctl.append & ~valid_reg & valid_lo;

    always_comb
    begin
        valid_next = valid_reg | load_app;
        match_next = ctl.lookup ? (valid_reg && (key_reg == cmp_key)) : match_reg;
        key_next   = key_reg;
        value_next = value_reg;
        priority if (shift)
        begin
            key_next   = key_hi;
            value_next = value_hi;
        end
        else if (load_top || load_app)
        begin
            key_next   = new_key;
            value_next = new_value;
        end
        else
        begin
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

### hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, lru replacement
// a row of cells ordered by recency, least recent at cell 0
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall, beat carries kind, key, value
//   output channel: out_valid / out_stall, beat carries found, result_value,
//   evicted, evicted_key; exactly one output beat per input beat, in order
//   config: cfg_wr_en / cfg_wr_data write the capacity register, only while idle
// timing
//   an input beat is taken in the cycle the block is idle; every cell compares
//   its key in that cycle and registers the match
//   the update state then closes the gap in the row, loads the top cell and
//   writes the result register once that register is free; no new beat is taken
//   until the update is done, as the compare-then-shift pass holds one item at a time
//   out_valid is registered and rises when the update writes the result register
// stall: the result register holds while out_stall is high; a following item
//   may be taken and compared but waits in its update cycle for the register
// reset: the row is empty, capacity resets to 16
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // config
    input  logic                     cfg_wr_en,
    input  logic [CAP_W-1:0]         cfg_wr_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     evicted,
    output logic signed [DATA_W-1:0] evicted_key
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              req_kind_reg;
    logic [DATA_W-1:0] req_key_reg;
    logic [DATA_W-1:0] req_value_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    logic [DATA_W-1:0] result_value_reg;
    logic              evicted_reg;
    logic [DATA_W-1:0] evicted_key_reg;

    // row wiring
    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] cell_match;
    logic [ENTRIES-1:0] ge_chain;
    logic [DATA_W-1:0]  cell_key   [ENTRIES];
    logic [DATA_W-1:0]  cell_value [ENTRIES];

    lrukv_ctl_t        ctl;
    logic              accept;
    logic              slot_free;
    logic              do_update;
    logic              hit;
    logic [DATA_W-1:0] hit_value;
    logic [CMP_W-1:0]  cap_eff;
    logic              over_cap;
    logic              evict;
    logic              row_empty;
    logic              evict_front;
    logic [DATA_W-1:0] top_value;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid & ~in_stall;
    assign slot_free = ~out_valid_reg | ~out_stall;
    assign do_update = (state_reg == ST_UPDATE) & slot_free;

    // effective capacity saturates at the row length
    assign cap_eff  = (CMP_W'(capacity_reg) > ENTRIES_C) ? ENTRIES_C : CMP_W'(capacity_reg);
    assign over_cap = (CMP_W'(count_reg) >= cap_eff);

    assign hit       = |cell_match;
    assign row_empty = ~cell_valid[0];
    assign evict     = (req_kind_reg == KIND_PUT) & ~hit & over_cap;
    // eviction of a stored entry drops cell 0 and moves everything down
    assign evict_front = evict & ~row_empty;

    // value of the single matching cell
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_value = hit_value | (cell_value[i] & {DATA_W{cell_match[i]}});
        end
    end

    // get keeps the stored value, put rewrites it
    assign top_value = (req_kind_reg == KIND_PUT) ? req_value_reg : hit_value;

    always_comb
    begin
        ctl.lookup = accept;
        ctl.move   = do_update & (hit | evict_front);
        ctl.append = do_update & (req_kind_reg == KIND_PUT) & ~hit & ~over_cap;
    end

    // recency row
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic              ge_in;
        logic              valid_lo;
        logic              valid_hi;
        logic [DATA_W-1:0] key_hi;
        logic [DATA_W-1:0] value_hi;

        if (i == 0)
        begin : g_first
            assign ge_in    = evict_front;
            assign valid_lo = 1'b1;
        end
        else
        begin : g_mid
            assign ge_in    = ge_chain[i-1];
            assign valid_lo = cell_valid[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_last
            assign valid_hi = 1'b0;
            assign key_hi   = '0;
            assign value_hi = '0;
        end
        else
        begin : g_inner
            assign valid_hi = cell_valid[i+1];
            assign key_hi   = cell_key[i+1];
            assign value_hi = cell_value[i+1];
        end

        lrukv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cmp_key   (key),
            .new_key   (req_key_reg),
            .new_value (top_value),
            .ge_in     (ge_in),
            .ge_out    (ge_chain[i]),
            .valid_lo  (valid_lo),
            .valid_hi  (valid_hi),
            .key_hi    (key_hi),
            .value_hi  (value_hi),
            .valid     (cell_valid[i]),
            .key       (cell_key[i]),
            .value     (cell_value[i]),
            .match     (cell_match[i])
        );
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_next = ctl.append ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (do_update)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_W'(16);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg  <= kind;
            req_key_reg   <= key;
            req_value_reg <= value;
        end
        if (do_update)
        begin
            found_reg <= hit;
            if (req_kind_reg == KIND_GET)
            begin
                result_value_reg <= hit ? hit_value : MISS_VALUE;
            end
            else
            begin
                result_value_reg <= '0;
            end
            evicted_reg <= evict;
            if (!evict)
            begin
                evicted_key_reg <= '0;
            end
            else if (row_empty)
            begin
                evicted_key_reg <= req_key_reg;
            end
            else
            begin
                evicted_key_reg <= cell_key[0];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign result_value = result_value_reg;
    assign evicted      = evicted_reg;
    assign evicted_key  = evicted_key_reg;

endmodule

### tb/sv/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the lru key-value cache
// a shadow copy of the recency row predicts every reply beat; gets and puts
// run through directed corner cases, then random phases under several
// capacity settings with random idling on both channels
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

    import lrukv_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 60;   // receiver hold-off that backs up the block
    localparam int SETTLE      = 4;    // idle cycles after the last reply
    localparam int SHOWN_MAX   = 20;   // mismatch lines printed before going quiet
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 53;

    // one reply beat as the block should produce it
    typedef struct {
        logic                     found;
        logic signed [DATA_W-1:0] result_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } cache_reply_t;

    // shadow of the recency row plus the queue of replies still owed
    class cache_scoreboard;
        logic signed [DATA_W-1:0] row_key [ENTRIES];
        logic signed [DATA_W-1:0] row_val [ENTRIES];
        int unsigned              used;
        int unsigned              capacity = ENTRIES;
        cache_reply_t             owed_replies [$];
        int                       errors;
        int                       gets;
        int                       puts;
        int                       hits;
        int                       evictions;
        int                       replies;

        function void set_capacity(input logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction

        // drop the entry at pos and close the gap towards the least recent end
        function void take_out(input int unsigned pos);
            for (int unsigned i = pos; i + 1 < used; i++)
            begin
                row_key[i] = row_key[i + 1];
                row_val[i] = row_val[i + 1];
            end
            used--;
        endfunction

        // place an entry at the most recent end
        function void put_top(input logic signed [DATA_W-1:0] k,
                              input logic signed [DATA_W-1:0] v);
            row_key[used] = k;
            row_val[used] = v;
            used++;
        endfunction

        // accepted request beat: work out its reply and update the shadow row
        function void note_request(input logic                     req_kind,
                                   input logic signed [DATA_W-1:0] req_key,
                                   input logic signed [DATA_W-1:0] req_value);
            cache_reply_t             r;
            int                       hit_pos;
            int unsigned              eff_cap;
            logic signed [DATA_W-1:0] stored;
            eff_cap = (capacity > ENTRIES) ? ENTRIES : capacity;
            hit_pos = -1;
            r.found        = 1'b0;
            r.result_value = '0;
            r.evicted      = 1'b0;
            r.evicted_key  = '0;
            for (int i = 0; i < int'(used); i++)
            begin
                if (hit_pos < 0 && row_key[i] == req_key)
                    hit_pos = i;
            end
            if (req_kind == KIND_GET)
                gets++;
            else
                puts++;

            if (hit_pos >= 0)
            begin
                hits++;
                stored  = row_val[hit_pos];
                r.found = 1'b1;
                if (req_kind == KIND_GET)
                    r.result_value = stored;
                else
                    stored = req_value;
                take_out(hit_pos);
                put_top(req_key, stored);
            end
            else if (req_kind == KIND_GET)
            begin
                r.result_value = MISS_VALUE;
            end
            else if (used + 1 > eff_cap)
            begin
                evictions++;
                r.evicted = 1'b1;
                if (used == 0)
                begin
                    // nothing held at capacity zero: the new entry goes straight out
                    r.evicted_key = req_key;
                end
                else
                begin
                    r.evicted_key = row_key[0];
                    take_out(0);
                    put_top(req_key, req_value);
                end
            end
            else
            begin
                put_top(req_key, req_value);
            end
            owed_replies.push_back(r);
        endfunction

        function void compare_field(input string                    name,
                                    input logic signed [DATA_W-1:0] want,
                                    input logic signed [DATA_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= SHOWN_MAX)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        // accepted reply beat: compare with the oldest owed reply
        function void check_reply(input logic                     f,
                                  input logic signed [DATA_W-1:0] rv,
                                  input logic                     ev,
                                  input logic signed [DATA_W-1:0] evk);
            cache_reply_t want;
            if (owed_replies.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_MAX)
                    $display("%0t: reply beat with none owed, expected nothing, %s",
                             $time, $sformatf("actual found %0b value %0d", f, rv));
                return;
            end
            want = owed_replies.pop_front();
            replies++;
            compare_field("found", {31'd0, want.found}, {31'd0, f});
            compare_field("result_value", want.result_value, rv);
            compare_field("evicted", {31'd0, want.evicted}, {31'd0, ev});
            compare_field("evicted_key", want.evicted_key, evk);
        endfunction
    endclass

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    // config port
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    // request channel
    logic                     in_valid;
    logic                     in_stall;
    logic                     kind;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    // reply channel
    logic                     out_valid;
    logic                     out_stall;
    logic                     found;
    logic signed [DATA_W-1:0] result_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;

    cache_scoreboard sb = new;

    // key pool so that random traffic hits stored entries often
    logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

    int  cycle_count;
    int  cap_writes;
    int  sender_calm;
    int  recv_calm;
    int  hold_asked;
    int  hold_served;
    bit  quiet_tail;

    lru_key_value_cache #(
        .ENTRIES      (ENTRIES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .result_value (result_value),
        .evicted      (evicted),
        .evicted_key  (evicted_key)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // both channels observed at the rising edge, beats go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(kind, key, value);
            if (out_valid && !out_stall)
                sb.check_reply(found, result_value, evicted, evicted_key);
        end
    end

    // receiver: random stall bursts, calm stretches, one long hold-off on request
    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served++;
                out_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (quiet_tail || recv_calm > 0)
            begin
                out_stall = 1'b0;
                if (recv_calm > 0)
                    recv_calm--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                burst     = $urandom_range(1, 18);
                out_stall = 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    recv_calm = $urandom_range(30, 90);
            end
        end
    end

    // one request beat, with an optional idle burst ahead of it
    task automatic send_request(input logic                     req_kind,
                                input logic signed [DATA_W-1:0] req_key,
                                input logic signed [DATA_W-1:0] req_val);
        int gap;
        gap = 0;
        if (!quiet_tail)
        begin
            if (sender_calm > 0)
                sender_calm--;
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    sender_calm = $urandom_range(15, 40);
                if ($urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 18);
            end
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = req_kind;
        key      = req_key;
        value    = req_val;
        // hold the beat until the block takes it
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait for every owed reply, then let the block settle
    task automatic drain_replies();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // capacity is only written once the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        drain_replies();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = c;
        @(posedge clk);
        sb.set_capacity(c);
        cap_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // random gets and puts, keys mostly drawn from the first span pool entries
    task automatic run_phase(input logic [CAP_W-1:0] c, input int span,
                             input bit long_hold);
        logic                     pick_kind;
        logic signed [DATA_W-1:0] pick_key;
        write_capacity(c);
        if (long_hold)
            hold_asked++;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pick_kind = ($urandom_range(0, 1) != 0) ? KIND_PUT : KIND_GET;
            if ($urandom_range(0, 6) == 0)
                pick_key = $urandom;
            else
                pick_key = key_pool[$urandom_range(0, span - 1)];
            send_request(pick_kind, pick_key, $urandom);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        kind        = KIND_GET;
        key         = '0;
        value       = '0;
        key_pool[0] = 32'sh7FFF_FFFF;
        key_pool[1] = 32'sh8000_0000;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // capacity zero on an empty store: puts bounce straight back out
        write_capacity(5'd0);
        send_request(KIND_GET, 32'sd0, 32'sd0);
        send_request(KIND_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(KIND_GET, 32'sh7FFF_FFFF, 32'sd0);
        send_request(KIND_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);

        // capacity above the row size saturates at ENTRIES
        write_capacity(5'd31);
        send_request(KIND_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(KIND_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(KIND_PUT, '1, '1);
        send_request(KIND_PUT, 32'sd0, 32'sd0);
        send_request(KIND_GET, 32'sh8000_0000, '1);
        // put on a hit rewrites the value and refreshes recency
        send_request(KIND_PUT, 32'sh7FFF_FFFF, 32'sd1234);
        send_request(KIND_GET, 32'sh7FFF_FFFF, 32'sd0);
        send_request(KIND_GET, 32'sd0, 32'sd0);
        // fill the row, then one more miss pushes out the least recent
        for (int i = 0; i < 12; i++)
            send_request(KIND_PUT, 32'sd100 + i, $urandom);
        send_request(KIND_PUT, 32'sd200, $urandom);

        // random phases; lowering capacity below the count is covered by 1 and 0
        run_phase(5'd16, 22, 1'b0);
        run_phase(5'd1,   3, 1'b1);
        run_phase(5'd31, 20, 1'b0);
        run_phase(5'd7,  10, 1'b0);
        run_phase(5'd0,   4, 1'b0);
        run_phase(5'd17, 24, 1'b0);
        run_phase(5'd12, 14, 1'b0);
        // last stretch with no idling on either side
        quiet_tail = 1'b1;
        run_phase(5'($urandom_range(0, 31)), 20, 1'b0);
        drain_replies();

        $display("tb: covered %0d requests (%0d gets, %0d puts) over %0d capacity writes",
                 sb.gets + sb.puts, sb.gets, sb.puts, cap_writes);
        $display("tb: %0d replies checked, %0d hits, %0d evictions, %0d mismatches",
                 sb.replies, sb.hits, sb.evictions, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
